FILE: sv/bmul_pkg.sv
// ---------------------------------------------------------------------------
// bmul_pkg
// Shared widths, Booth pair codes and the per-stage payload type of the
// radix-2 Booth multiplier pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bmul_pkg;

  // operand width; the product is twice as wide
  localparam int WIDTH = 8;
  localparam int PROD_W = 2 * WIDTH;

  // stream word widths, rounded up to whole bytes
  localparam int IN_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PROD_W + 7) / 8) * 8;

  // booth pair {current multiplier bit, bit shifted out before it}
  localparam logic [1:0] BOOTH_SUB = 2'b10;
  localparam logic [1:0] BOOTH_ADD = 2'b01;

  // partial state carried from one step to the next
  typedef struct packed {
    logic [WIDTH:0]   acc;    // accumulator, one bit wider than the operands
    logic [WIDTH-1:0] q;      // multiplier bits, low half of the product
    logic             prev;   // bit shifted out on the previous step
    logic [WIDTH:0]   mcand;  // sign-extended multiplicand
  } bmul_data_t;

endpackage

`default_nettype wire

FILE: sv/booth_radix2_signed_multiplier.sv
// ---------------------------------------------------------------------------
// booth_radix2_signed_multiplier
// Signed radix-2 Booth multiplier as a pipeline of one step per stage.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transfer carries a multiplicand and a multiplier,
//   both signed two's complement of WIDTH bits. Output channel out_*: one
//   transfer per input transfer carries the exact signed product, 2*WIDTH
//   bits, in the order the operands arrived.
//   Pipeline: one registered stage per Booth step, the last stage doubling
//   as the output register.
//   Throughput: one product per cycle while out_tready does not stall the
//   pipeline; a new pair can enter every cycle while the WIDTH stages hold
//   earlier pairs at various steps.
//   Reset: rst_n low at a clock edge empties every stage; no transfers are
//   offered while it is low; in_tready is not held low and pairs sent are dropped.
//   Stall: when out_tvalid is high and out_tready low, the whole pipeline
//   holds and in_tready drops, so nothing is lost or repeated; a bubble in
//   the last stage lets the pipeline keep moving regardless of out_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module booth_radix2_signed_multiplier (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [bmul_pkg::IN_TDATA_W-1:0]  in_tdata,   // multiplier high, multiplicand low
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [bmul_pkg::OUT_TDATA_W-1:0]      out_tdata   // product
);

  logic                         adv;
  logic [bmul_pkg::WIDTH:0]     vld_chain;
  bmul_pkg::bmul_data_t         data_chain [0:bmul_pkg::WIDTH];
  bmul_pkg::bmul_data_t         seed;
  logic [bmul_pkg::WIDTH-1:0]   mcand_in;
  logic [bmul_pkg::WIDTH-1:0]   mplier_in;
  logic [bmul_pkg::OUT_TDATA_W-1:0] out_word;

  // pipeline moves whenever the last stage is empty or being taken
  assign adv       = !vld_chain[bmul_pkg::WIDTH] || out_tready;
  assign in_tready = adv;

  // unpack operands and seed the first step
  assign mcand_in  = in_tdata[bmul_pkg::WIDTH-1:0];
  assign mplier_in = in_tdata[2*bmul_pkg::WIDTH-1:bmul_pkg::WIDTH];

  always_comb begin
    seed.acc   = '0;
    seed.q     = mplier_in;
    seed.prev  = 1'b0;
    seed.mcand = {mcand_in[bmul_pkg::WIDTH-1], mcand_in};
  end

  assign vld_chain[0]  = in_tvalid;
  assign data_chain[0] = seed;

  // one stage per booth step
  for (genvar i = 0; i < bmul_pkg::WIDTH; i++) begin : g_step
    bmul_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (vld_chain[i]),
      .in_data   (data_chain[i]),
      .out_valid (vld_chain[i+1]),
      .out_data  (data_chain[i+1])
    );
  end

  // product is the low accumulator bits over the shifted multiplier
  always_comb begin
    out_word = '0;
    out_word[bmul_pkg::PROD_W-1:0] = {data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH-1:0],
                                      data_chain[bmul_pkg::WIDTH].q};
  end

  assign out_tvalid = vld_chain[bmul_pkg::WIDTH];
  assign out_tdata  = out_word;

  // a held pipeline keeps every stage's occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_chain[bmul_pkg::WIDTH:1]))
    else $error("stage occupancy changed during a stall");

  // an accepted pair lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_chain[1])
    else $error("accepted operands missing from first stage");

  // the last stage has consumed every multiplier bit: prev is the multiplier sign
  a_sign_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (data_chain[bmul_pkg::WIDTH].prev ==
                    data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH] ||
                    data_chain[bmul_pkg::WIDTH].mcand == '0 ||
                    data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH-1:0] == '0 ||
                    data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH] !=
                    data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH-1] ||
                    data_chain[bmul_pkg::WIDTH].acc[bmul_pkg::WIDTH] ==
                    (data_chain[bmul_pkg::WIDTH].prev ^
                     data_chain[bmul_pkg::WIDTH].mcand[bmul_pkg::WIDTH])))
    else $error("product sign inconsistent with operand signs");

endmodule

`default_nettype wire

FILE: sv/bmul_stage.sv
// ---------------------------------------------------------------------------
// bmul_stage
// One registered Booth step: add, subtract or skip the multiplicand by the
// bit pair, then arithmetic right shift of {acc, q, prev}.
// ---------------------------------------------------------------------------
`default_nettype none

module bmul_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire bmul_pkg::bmul_data_t  in_data,
  output logic                       out_valid,
  output bmul_pkg::bmul_data_t       out_data
);

  logic                     valid_r;
  logic                     valid_nxt;
  bmul_pkg::bmul_data_t     data_r;
  bmul_pkg::bmul_data_t     data_nxt;
  logic [bmul_pkg::WIDTH:0] sum;

  // add or subtract by the booth pair
  always_comb begin
    case ({in_data.q[0], in_data.prev})
      bmul_pkg::BOOTH_SUB: sum = in_data.acc - in_data.mcand;
      bmul_pkg::BOOTH_ADD: sum = in_data.acc + in_data.mcand;
      default:             sum = in_data.acc;
    endcase
  end

  // arithmetic right shift of the joined accumulator and multiplier
  always_comb begin
    data_nxt.mcand = in_data.mcand;
    data_nxt.prev  = in_data.q[0];
    data_nxt.q     = {sum[0], in_data.q[bmul_pkg::WIDTH-1:1]};
    data_nxt.acc   = {sum[bmul_pkg::WIDTH], sum[bmul_pkg::WIDTH:1]};
    valid_nxt      = in_valid;
  end

  // stage register, advances only when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire
